[hw/rtl/cmfs_pkg.sv]
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared constants, face codes and transfer structs for the cube map face
// select pipeline.
// ----------------------------------------------------------------------------
package cmfs_pkg;

   localparam int COMP_BITS = 16;               // direction component width
   localparam int FRAC_BITS = 16;               // fraction bits of s and t
   localparam int FACE_W    = 3;
   localparam int COORD_W   = FRAC_BITS + 1;    // covers 0 .. 1.0 inclusive
   localparam int MAG_W     = COMP_BITS;        // |component| <= 2^(COMP_BITS-1)
   localparam int DIV_W     = COMP_BITS + 1;    // divisor 2*|major|
   localparam int REM_W     = COMP_BITS + 2;    // remainder, kept below 2*divisor
   localparam int QUO_W     = FRAC_BITS + 2;    // quotient before rounding
   localparam int NUM_CELLS = QUO_W;            // one divider cell per bit

   // front stage + divider cells + output register
   localparam int PIPE_LATENCY = NUM_CELLS + 2;

   localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << FRAC_BITS;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] dir_x;
      logic signed [COMP_BITS-1:0] dir_y;
      logic signed [COMP_BITS-1:0] dir_z;
   } req_type;

   typedef struct packed {
      face_type            face;
      logic [COORD_W-1:0]  coord_s;
      logic [COORD_W-1:0]  coord_t;
      logic                zero_vector;
   } rsp_type;

   // Data handed from one divider cell to the next
   typedef struct packed {
      logic                valid;
      logic                zero;
      face_type            face;
      logic [DIV_W-1:0]    divisor;
      logic [REM_W-1:0]    rem_s;
      logic [REM_W-1:0]    rem_t;
      logic [QUO_W-1:0]    quo_s;
      logic [QUO_W-1:0]    quo_t;
   } cell_type;

endpackage

[hw/rtl/cmfs_front.sv]
// ----------------------------------------------------------------------------
// cmfs_front
// Axis permute, major axis pick, face code and minor component select.
// Loads the first divider cell with numerator offset and divisor.
// ----------------------------------------------------------------------------
module cmfs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cmfs_pkg::req_type  req,
   output cmfs_pkg::cell_type cell_out
);

   logic signed [cmfs_pkg::COMP_BITS:0] gx, gy, gz;
   logic signed [cmfs_pkg::COMP_BITS:0] neg_gx, neg_gy, neg_gz;
   logic signed [cmfs_pkg::COMP_BITS:0] abs_x, abs_y, abs_z;
   logic [cmfs_pkg::MAG_W-1:0]          ax, ay, az, ama;
   logic signed [cmfs_pkg::COMP_BITS:0] sc, tc;
   logic [cmfs_pkg::REM_W-1:0]          sum_s, sum_t;
   cmfs_pkg::face_type                  face;
   cmfs_pkg::cell_type                  data_in;
   cmfs_pkg::cell_type                  data_ff;
   logic                                valid_ff;

   // GL axes: (x, y, z) = (dir_y, dir_z, dir_x), one bit wider for negation
   assign gx = {req.dir_y[cmfs_pkg::COMP_BITS-1], req.dir_y};
   assign gy = {req.dir_z[cmfs_pkg::COMP_BITS-1], req.dir_z};
   assign gz = {req.dir_x[cmfs_pkg::COMP_BITS-1], req.dir_x};

   assign neg_gx = -gx;
   assign neg_gy = -gy;
   assign neg_gz = -gz;

   assign abs_x = gx[cmfs_pkg::COMP_BITS] ? neg_gx : gx;
   assign abs_y = gy[cmfs_pkg::COMP_BITS] ? neg_gy : gy;
   assign abs_z = gz[cmfs_pkg::COMP_BITS] ? neg_gz : gz;

   assign ax = abs_x[cmfs_pkg::MAG_W-1:0];
   assign ay = abs_y[cmfs_pkg::MAG_W-1:0];
   assign az = abs_z[cmfs_pkg::MAG_W-1:0];

   always_comb begin
      priority if (ax >= ay && ax >= az) begin
         face = gx[cmfs_pkg::COMP_BITS] ? cmfs_pkg::FACE_NEG_X : cmfs_pkg::FACE_POS_X;
         ama  = ax;
      end else if (ay >= az) begin
         face = gy[cmfs_pkg::COMP_BITS] ? cmfs_pkg::FACE_NEG_Y : cmfs_pkg::FACE_POS_Y;
         ama  = ay;
      end else begin
         face = gz[cmfs_pkg::COMP_BITS] ? cmfs_pkg::FACE_NEG_Z : cmfs_pkg::FACE_POS_Z;
         ama  = az;
      end
   end

   always_comb begin
      unique case (face)
         cmfs_pkg::FACE_POS_X: begin sc = neg_gz; tc = neg_gy; end
         cmfs_pkg::FACE_NEG_X: begin sc = gz;     tc = neg_gy; end
         cmfs_pkg::FACE_POS_Y: begin sc = gx;     tc = gz;     end
         cmfs_pkg::FACE_NEG_Y: begin sc = gx;     tc = neg_gz; end
         cmfs_pkg::FACE_POS_Z: begin sc = gx;     tc = neg_gy; end
         cmfs_pkg::FACE_NEG_Z: begin sc = neg_gx; tc = neg_gy; end
         default:              begin sc = neg_gx; tc = neg_gy; end
      endcase
   end

   // minor + |major| lies in [0, 2*|major|]
   assign sum_s = {sc[cmfs_pkg::COMP_BITS], sc} + {2'b00, ama};
   assign sum_t = {tc[cmfs_pkg::COMP_BITS], tc} + {2'b00, ama};

   always_comb begin
      data_in         = '0;
      data_in.zero    = (ax == '0) && (ay == '0) && (az == '0);
      data_in.face    = face;
      data_in.divisor = {ama, 1'b0};
      data_in.rem_s   = sum_s;
      data_in.rem_t   = sum_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

[hw/rtl/cmfs_div_cell.sv]
// ----------------------------------------------------------------------------
// cmfs_div_cell
// One restoring divide step for both coordinates: compare, subtract,
// shift in a quotient bit, double the remainder for the next cell.
// ----------------------------------------------------------------------------
module cmfs_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  cmfs_pkg::cell_type cell_in,
   output cmfs_pkg::cell_type cell_out
);

   logic [cmfs_pkg::REM_W-1:0] div_ext;
   logic                       ge_s, ge_t;
   logic [cmfs_pkg::REM_W-1:0] diff_s, diff_t;
   cmfs_pkg::cell_type         data_in;
   cmfs_pkg::cell_type         data_ff;
   logic                       valid_ff;

   assign div_ext = {1'b0, cell_in.divisor};

   assign ge_s   = cell_in.rem_s >= div_ext;
   assign ge_t   = cell_in.rem_t >= div_ext;
   assign diff_s = cell_in.rem_s - (ge_s ? div_ext : '0);
   assign diff_t = cell_in.rem_t - (ge_t ? div_ext : '0);

   // diff stays below the divisor, so doubling fits
   always_comb begin
      data_in       = cell_in;
      data_in.rem_s = {diff_s[cmfs_pkg::REM_W-2:0], 1'b0};
      data_in.rem_t = {diff_t[cmfs_pkg::REM_W-2:0], 1'b0};
      data_in.quo_s = {cell_in.quo_s[cmfs_pkg::QUO_W-2:0], ge_s};
      data_in.quo_t = {cell_in.quo_t[cmfs_pkg::QUO_W-2:0], ge_t};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

`ifndef ASSERT_OFF
   // remainder handed on must stay below twice the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !data_ff.zero) |->
         (data_ff.rem_s < {data_ff.divisor, 1'b0}) &&
         (data_ff.rem_t < {data_ff.divisor, 1'b0}))
      else $error("divider remainder out of range");
`endif

endmodule

[hw/rtl/cube_map_face_select.sv]
// Path from start to rsp_valid: front stage, divider cells, output register.
// Throughput: one direction per cycle; busy is never raised.
// Rate set by the row of divider cells, one quotient bit per cell per cycle.
// The receiver cannot stall; rsp_valid is a one-cycle strobe.
// Synchronous reset clears all valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// cube_map_face_select
// Picks the cube map face for a z-up direction vector and computes the
// in-face s, t coordinates through a pipelined restoring divider.
// ----------------------------------------------------------------------------
module cube_map_face_select (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cmfs_pkg::req_type req_payload,
   output logic              rsp_valid,
   output cmfs_pkg::rsp_type rsp_payload
);

   cmfs_pkg::cell_type          link [cmfs_pkg::NUM_CELLS+1];
   cmfs_pkg::cell_type          last;
   logic [cmfs_pkg::QUO_W-1:0]  rnd_s, rnd_t;
   cmfs_pkg::rsp_type           rsp_in;
   cmfs_pkg::rsp_type           rsp_payload_ff;
   logic                        rsp_valid_ff;

   assign busy = 1'b0;

   cmfs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .req      (req_payload),
      .cell_out (link[0])
   );

   for (genvar i = 0; i < cmfs_pkg::NUM_CELLS; i++) begin : g_cell
      cmfs_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (link[i]),
         .cell_out (link[i+1])
      );
   end

   assign last = link[cmfs_pkg::NUM_CELLS];

   // quotient carries one extra bit: round half up by add one and drop it
   assign rnd_s = last.quo_s + cmfs_pkg::QUO_W'(1);
   assign rnd_t = last.quo_t + cmfs_pkg::QUO_W'(1);

   always_comb begin
      rsp_in.zero_vector = last.zero;
      if (last.zero) begin
         rsp_in.face    = cmfs_pkg::FACE_POS_X;
         rsp_in.coord_s = '0;
         rsp_in.coord_t = '0;
      end else begin
         rsp_in.face    = last.face;
         rsp_in.coord_s = rnd_s[cmfs_pkg::QUO_W-1:1];
         rsp_in.coord_t = rnd_t[cmfs_pkg::QUO_W-1:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   // every result traces back to a transfer a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start, cmfs_pkg::PIPE_LATENCY))
      else $error("result without matching request");
`endif

`ifndef ASSERT_OFF
   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.coord_s <= cmfs_pkg::COORD_ONE) &&
                       (rsp_payload_ff.coord_t <= cmfs_pkg::COORD_ONE))
      else $error("coordinate above 1.0");
`endif

`ifndef ASSERT_OFF
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.zero_vector) |->
         $past((req_payload.dir_x == '0) && (req_payload.dir_y == '0) &&
               (req_payload.dir_z == '0), cmfs_pkg::PIPE_LATENCY))
      else $error("zero flag on nonzero direction");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cube_map_face_select. Directions are pushed through
// the start/busy port with random gaps; each accepted direction is run
// through an in-bench face and s,t predictor, and every rsp_valid strobe is
// compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

   class face_scoreboard;
      cmfs_pkg::rsp_type expected_faces[$];
      int                errors;

      function new();
         errors = 0;
      endfunction

      // round half up of 2^FRAC_BITS * ((num / m) + 1) / 2, num in [-m, m]
      function logic [cmfs_pkg::COORD_W-1:0] scale_coord(longint num, longint m);
         return cmfs_pkg::COORD_W'((((num + m) <<< cmfs_pkg::FRAC_BITS) + m) / (2 * m));
      endfunction

      function cmfs_pkg::rsp_type predict_face(cmfs_pkg::req_type d);
         longint            gx, gy, gz;
         longint            ax, ay, az;
         longint            major_mag, sc, tc;
         cmfs_pkg::rsp_type r;
         r  = '0;
         // z-up to GL axes: (x, y, z) = (dir_y, dir_z, dir_x)
         gx = longint'($signed(d.dir_y));
         gy = longint'($signed(d.dir_z));
         gz = longint'($signed(d.dir_x));
         ax = (gx < 0) ? -gx : gx;
         ay = (gy < 0) ? -gy : gy;
         az = (gz < 0) ? -gz : gz;
         if (ax == 0 && ay == 0 && az == 0) begin
            r.zero_vector = 1'b1;
            return r;
         end
         // ties go to the lowest GL axis
         if (ax >= ay && ax >= az) begin
            major_mag = ax;
            r.face = (gx < 0) ? cmfs_pkg::FACE_NEG_X : cmfs_pkg::FACE_POS_X;
         end else if (ay >= az) begin
            major_mag = ay;
            r.face = (gy < 0) ? cmfs_pkg::FACE_NEG_Y : cmfs_pkg::FACE_POS_Y;
         end else begin
            major_mag = az;
            r.face = (gz < 0) ? cmfs_pkg::FACE_NEG_Z : cmfs_pkg::FACE_POS_Z;
         end
         case (r.face)
            cmfs_pkg::FACE_POS_X: begin sc = -gz; tc = -gy; end
            cmfs_pkg::FACE_NEG_X: begin sc =  gz; tc = -gy; end
            cmfs_pkg::FACE_POS_Y: begin sc =  gx; tc =  gz; end
            cmfs_pkg::FACE_NEG_Y: begin sc =  gx; tc = -gz; end
            cmfs_pkg::FACE_POS_Z: begin sc =  gx; tc = -gy; end
            default:              begin sc = -gx; tc = -gy; end
         endcase
         r.coord_s = scale_coord(sc, major_mag);
         r.coord_t = scale_coord(tc, major_mag);
         return r;
      endfunction

      function void note_direction(cmfs_pkg::req_type d);
         expected_faces.push_back(predict_face(d));
      endfunction

      function void check_face(cmfs_pkg::rsp_type got);
         cmfs_pkg::rsp_type exp;
         if (expected_faces.size() == 0) begin
            $display("%0t: unexpected result face %0d s %0d t %0d zero %0b", $time,
                     got.face, got.coord_s, got.coord_t, got.zero_vector);
            errors++;
            return;
         end
         exp = expected_faces.pop_front();
         if (got.face !== exp.face) begin
            $display("%0t: face mismatch, expected %0d, got %0d", $time, exp.face, got.face);
            errors++;
         end
         if (got.coord_s !== exp.coord_s) begin
            $display("%0t: coord_s mismatch, expected %0d, got %0d", $time,
                     exp.coord_s, got.coord_s);
            errors++;
         end
         if (got.coord_t !== exp.coord_t) begin
            $display("%0t: coord_t mismatch, expected %0d, got %0d", $time,
                     exp.coord_t, got.coord_t);
            errors++;
         end
         if (got.zero_vector !== exp.zero_vector) begin
            $display("%0t: zero_vector mismatch, expected %0b, got %0b", $time,
                     exp.zero_vector, got.zero_vector);
            errors++;
         end
      endfunction

      function int pending();
         return expected_faces.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   cmfs_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   cmfs_pkg::rsp_type rsp_payload;

   face_scoreboard sb = new();

   cube_map_face_select u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // transfer on start && !busy; results on the strobe
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_direction(req_payload);
      if (!reset && rsp_valid)
         sb.check_face(rsp_payload);
   end

   function automatic cmfs_pkg::req_type make_dir(int x, int y, int z);
      cmfs_pkg::req_type d;
      d.dir_x = cmfs_pkg::COMP_BITS'(x);
      d.dir_y = cmfs_pkg::COMP_BITS'(y);
      d.dir_z = cmfs_pkg::COMP_BITS'(z);
      return d;
   endfunction

   function automatic int rand_sign(int v);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic cmfs_pkg::req_type random_dir();
      int                mode;
      int                m;
      cmfs_pkg::req_type d;
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
         d.dir_x = cmfs_pkg::COMP_BITS'($urandom);
         d.dir_y = cmfs_pkg::COMP_BITS'($urandom);
         d.dir_z = cmfs_pkg::COMP_BITS'($urandom);
      end else if (mode < 8) begin
         // small magnitudes give frequent ties and zeros
         d = make_dir(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
                      int'($urandom_range(0, 8)) - 4);
      end else if (mode == 8) begin
         m = $urandom_range(1, 32767);
         d = make_dir(rand_sign(m), rand_sign(m), rand_sign($urandom_range(0, m)));
         if ($urandom_range(0, 1))
            d = make_dir(rand_sign($urandom_range(0, m)), rand_sign(m), rand_sign(m));
      end else begin
         d = make_dir($urandom_range(0, 2) == 0 ? -32768 : rand_sign(32767),
                      rand_sign($urandom_range(0, 1) ? 32767 : 1),
                      $urandom_range(0, 3) == 0 ? 0 : -32768);
      end
      return d;
   endfunction

   task automatic send_dir(cmfs_pkg::req_type d);
      start       <= 1'b1;
      req_payload <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(0, 99) < 16) begin
         start       <= 1'b0;
         req_payload <= random_dir();
         @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   cmfs_pkg::req_type directed[$];

   initial begin
      directed = '{
         make_dir(0, 0, 0),
         make_dir(0, 32767, 0),  make_dir(0, -32767, 0),   // +X / -X
         make_dir(0, 0, 32767),  make_dir(0, 0, -32767),   // +Y / -Y
         make_dir(32767, 0, 0),  make_dir(-32767, 0, 0),   // +Z / -Z
         make_dir(1, 1, 1),      make_dir(-1, -1, -1),     // three-way tie
         make_dir(5, -7, 7),     make_dir(9, -3, -9),      // two-way ties
         make_dir(-32768, 0, 0), make_dir(0, -32768, 0),   // most negative
         make_dir(0, 0, -32768), make_dir(-32768, -32768, -32768),
         make_dir(32767, 32767, -32767), make_dir(-32767, -32767, 32767),
         make_dir(32767, 1, -32768), make_dir(-32767, 32767, 1),
         make_dir(1, 0, 0),      make_dir(0, -1, 0),
         make_dir(12345, -20000, 700), make_dir(-3, 2, -1),
         make_dir(32766, -32767, 32767)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_dir(directed[i]);
         maybe_idle();
      end
      drain();

      for (int i = 0; i < 400; i++) begin
         send_dir(random_dir());
         if (i == 300)
            drain();
         else if (i < 120 || i >= 220)
            maybe_idle();
      end

      drain();
      repeat (cmfs_pkg::PIPE_LATENCY + 4) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
